### rtl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// MPE touch tracker package
// Shared types, message codes and result builders for the touch tracker.
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam int NUM_CHANNELS = 16;

    // Message type codes, upper nibble of the status byte.
    localparam logic [3:0] MSG_NOTE_OFF  = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON   = 4'h9;
    localparam logic [3:0] MSG_CTRL_CHG  = 4'hB;
    localparam logic [3:0] MSG_CHAN_PRES = 4'hD;
    localparam logic [3:0] MSG_PITCH_BND = 4'hE;

    // Controller number that carries timbre in MPE mode.
    localparam logic [6:0] CC_TIMBRE = 7'd74;

    // Control numbers reported for pressure and bend in plain mode.
    localparam logic [7:0] CTRL_NUM_PRESSURE = 8'hD0;
    localparam logic [7:0] CTRL_NUM_BEND     = 8'hE0;

    // Configuration register indexes.
    localparam logic [1:0] REG_MPE_MODE   = 2'd0;
    localparam logic [1:0] REG_BEND_RANGE = 2'd1;

    localparam logic [6:0] BEND_RANGE_RESET = 7'd48;

    typedef enum logic [1:0] {
        KIND_ON   = 2'd0,
        KIND_CONT = 2'd1,
        KIND_OFF  = 2'd2,
        KIND_CTRL = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] first_data;
        logic [6:0] second_data;
    } t_item;

    typedef struct packed {
        t_kind              event_kind;
        logic [3:0]         touch_id;
        logic signed [16:0] note_pos;
        logic signed [13:0] x_bend;
        logic [6:0]         y_timbre;
        logic [6:0]         z_pressure;
        logic [7:0]         control_number;
        logic signed [13:0] control_level;
        logic               last_of_run;
    } t_result;

    // Results of one processed item, handed to the output queue.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic t_result mk_touch(t_kind kind, logic [3:0] id,
                                         logic signed [16:0] note,
                                         logic signed [13:0] bend,
                                         logic [6:0] y, logic [6:0] z);
        t_result r;
        r                = '0;
        r.event_kind     = kind;
        r.touch_id       = id;
        r.note_pos       = note;
        r.x_bend         = bend;
        r.y_timbre       = y;
        r.z_pressure     = z;
        return r;
    endfunction

    function automatic t_result mk_ctrl(logic [7:0] number,
                                        logic signed [13:0] level);
        t_result r;
        r                = '0;
        r.event_kind     = KIND_CTRL;
        r.control_number = number;
        r.control_level  = level;
        return r;
    endfunction

endpackage

### rtl/mpe_midi_to_touch_tracker_unit.sv
// ----------------------------------------------------------------------------
// MPE MIDI to touch tracker
// Turns MIDI channel messages into per-channel touch and control events.
// ----------------------------------------------------------------------------
// A message is captured in the input register, processed once the result
// queue has room, and its results are written into that queue for the output.
// Throughput: one message per cycle while results are taken; a note-on that
// restarts an active touch gives two results, and the single output port
// then hands them out one at a time.
// Reset: synchronous, active low; clears every touch record, sets MPE mode
// on and a bend range of 48 semitones, and empties the result queue.
module mpe_midi_to_touch_tracker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input message stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] status_byte, [14:8] first_data, [21:15] second_data, [23:22] zero
    input  logic [23:0] s_axis_tdata,
    // Configuration writes: index 0 is mpe_mode, index 1 is bend_range.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    // Output event stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] touch_id, [20:4] note_pos, [34:21] x_bend, [41:35] y_timbre,
    // [48:42] z_pressure, [56:49] control_number, [70:57] control_level,
    // [71] zero
    output logic [71:0] m_axis_tdata,
    // [1:0] event_kind
    output logic [1:0]  m_axis_tuser,
    // last_of_run: set on the final event caused by one message
    output logic        m_axis_tlast
);
    import mtt_pkg::*;

    t_item   item;
    t_push   push;
    t_result result;
    logic    room;

    // Unpack the message fields from the input transfer.
    assign item.status_byte = s_axis_tdata[7:0];
    assign item.first_data  = s_axis_tdata[14:8];
    assign item.second_data = s_axis_tdata[21:15];

    // Registers can be written in any cycle; software must write them only while
    // the tracker is idle, which the block itself does not enforce.
    assign o_cfg_ready = 1'b1;

    // The core holds the input register and the touch store; it only moves
    // a message forward when the queue has space for two results.
    mtt_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_item       (item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_room       (room),
        .o_push       (push)
    );

    // The result queue decouples the core from stalls on the output side.
    mtt_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {1'b0, result.control_level, result.control_number,
                           result.z_pressure, result.y_timbre, result.x_bend,
                           result.note_pos, result.touch_id};
    assign m_axis_tuser = result.event_kind;
    assign m_axis_tlast = result.last_of_run;

endmodule

### rtl/mtt_core.sv
// ----------------------------------------------------------------------------
// MPE touch tracker core
// Input register, per-channel touch store and the single-pass event logic.
// ----------------------------------------------------------------------------
module mtt_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    output logic           o_item_ready,
    input  mtt_pkg::t_item i_item,
    input  logic           i_cfg_valid,
    input  logic [1:0]     i_cfg_index,
    input  logic [6:0]     i_cfg_data,
    input  logic           i_room,
    output mtt_pkg::t_push o_push
);
    import mtt_pkg::*;

    logic       r_mpe_mode;
    logic [6:0] r_bend_range;

    logic  r_in_valid;
    t_item r_in;

    logic               r_active  [NUM_CHANNELS];
    logic [6:0]         r_start   [NUM_CHANNELS];
    logic signed [16:0] r_note    [NUM_CHANNELS];
    logic signed [13:0] r_bend    [NUM_CHANNELS];
    logic [6:0]         r_timbre  [NUM_CHANNELS];
    logic [6:0]         r_press   [NUM_CHANNELS];

    logic               n_active;
    logic [6:0]         n_start;
    logic signed [16:0] n_note;
    logic signed [13:0] n_bend;
    logic [6:0]         n_timbre;
    logic [6:0]         n_press;

    logic               fire;
    logic [3:0]         ch;
    logic [3:0]         msg;
    logic [6:0]         d1;
    logic [6:0]         d2;
    logic signed [13:0] bend_off;
    logic signed [20:0] bend_prod;
    logic signed [15:0] bend_term;
    logic signed [16:0] d1_note;
    logic               off_ev;
    logic               on_ev;
    t_push              push;

    assign fire         = r_in_valid && i_room;
    assign o_item_ready = !r_in_valid || i_room;

    assign ch  = r_in.status_byte[3:0];
    assign msg = r_in.status_byte[7:4];
    assign d1  = r_in.first_data;
    assign d2  = r_in.second_data;

    // Raw 14-bit bend minus center is the raw value with its top bit flipped.
    assign bend_off  = {~d2[6], d2[5:0], d1};
    assign bend_prod = 21'(bend_off) * $signed({14'd0, r_bend_range});
    assign bend_term = 16'(bend_prod >>> 5);
    assign d1_note   = $signed({2'b00, d1, 8'h00});

    always_comb begin
        n_active = r_active[ch];
        n_start  = r_start[ch];
        n_note   = r_note[ch];
        n_bend   = r_bend[ch];
        n_timbre = r_timbre[ch];
        n_press  = r_press[ch];
        push     = '0;
        off_ev   = 1'b0;
        on_ev    = 1'b0;
        case (msg)
            MSG_NOTE_ON: begin
                off_ev = r_mpe_mode && (r_active[ch] || d2 == 7'd0);
                on_ev  = !(r_mpe_mode && d2 == 7'd0);
                if (off_ev) begin
                    push.res0 = mk_touch(KIND_OFF, ch, r_note[ch], r_bend[ch], 7'd0, 7'd0);
                    n_active  = 1'b0;
                    n_start   = 7'd0;
                    n_timbre  = 7'd0;
                    n_press   = 7'd0;
                end
                if (on_ev) begin
                    n_active = 1'b1;
                    n_start  = d1;
                    n_note   = d1_note;
                    n_bend   = '0;
                    n_timbre = 7'd0;
                    n_press  = d2;
                    if (off_ev) begin
                        push.res1 = mk_touch(KIND_ON, ch, d1_note, '0, 7'd0, d2);
                    end else begin
                        push.res0 = mk_touch(KIND_ON, ch, d1_note, '0, 7'd0, d2);
                    end
                end
                push.count = {1'b0, off_ev} + {1'b0, on_ev};
            end
            MSG_NOTE_OFF: begin
                if (!r_mpe_mode) begin
                    n_note = d1_note;
                    n_bend = '0;
                end
                n_timbre   = 7'd0;
                n_press    = d2;
                n_active   = 1'b0;
                n_start    = 7'd0;
                push.res0  = mk_touch(KIND_OFF, ch, n_note, n_bend, 7'd0, d2);
                push.count = 2'd1;
            end
            MSG_CTRL_CHG: begin
                if (r_mpe_mode && d1 == CC_TIMBRE) begin
                    if (r_active[ch]) begin
                        n_timbre   = d2;
                        push.res0  = mk_touch(KIND_CONT, ch, r_note[ch], r_bend[ch],
                                              d2, r_press[ch]);
                        push.count = 2'd1;
                    end
                end else begin
                    push.res0  = mk_ctrl({1'b0, d1}, $signed({7'd0, d2}));
                    push.count = 2'd1;
                end
            end
            MSG_CHAN_PRES: begin
                if (r_mpe_mode) begin
                    if (r_active[ch]) begin
                        n_press    = d1;
                        push.res0  = mk_touch(KIND_CONT, ch, r_note[ch], r_bend[ch],
                                              r_timbre[ch], d1);
                        push.count = 2'd1;
                    end
                end else begin
                    push.res0  = mk_ctrl(CTRL_NUM_PRESSURE, $signed({7'd0, d1}));
                    push.count = 2'd1;
                end
            end
            MSG_PITCH_BND: begin
                if (r_mpe_mode) begin
                    if (r_active[ch]) begin
                        n_note     = $signed({2'b00, r_start[ch], 8'h00}) + 17'(bend_term);
                        n_bend     = bend_off;
                        push.res0  = mk_touch(KIND_CONT, ch, n_note, bend_off,
                                              r_timbre[ch], r_press[ch]);
                        push.count = 2'd1;
                    end
                end else begin
                    push.res0  = mk_ctrl(CTRL_NUM_BEND, bend_off);
                    push.count = 2'd1;
                end
            end
            default: begin
                push.count = 2'd0;
            end
        endcase
        // Mark the final result of this item.
        if (push.count == 2'd2) begin
            push.res1.last_of_run = 1'b1;
        end else begin
            push.res0.last_of_run = 1'b1;
        end
        if (!fire) begin
            push.count = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpe_mode   <= 1'b1;
            r_bend_range <= BEND_RANGE_RESET;
            r_in_valid   <= 1'b0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_active[k] <= 1'b0;
                r_start[k]  <= '0;
                r_note[k]   <= '0;
                r_bend[k]   <= '0;
                r_timbre[k] <= '0;
                r_press[k]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MPE_MODE:   r_mpe_mode   <= i_cfg_data[0];
                    REG_BEND_RANGE: r_bend_range <= i_cfg_data;
                    default:        ;
                endcase
            end
            if (o_item_ready) begin
                r_in_valid <= i_item_valid;
            end
            if (fire) begin
                r_active[ch] <= n_active;
                r_start[ch]  <= n_start;
                r_note[ch]   <= n_note;
                r_bend[ch]   <= n_bend;
                r_timbre[ch] <= n_timbre;
                r_press[ch]  <= n_press;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_ready && i_item_valid) begin
            r_in <= i_item;
        end
    end

endmodule

### rtl/mtt_fifo.sv
// ----------------------------------------------------------------------------
// MPE touch tracker result queue
// Four-entry queue that takes up to two results and gives one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module mtt_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mtt_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output mtt_pkg::t_result o_result
);
    import mtt_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_count;
    logic       pop;
    logic [1:0] wr_next;

    assign o_valid  = r_count != 3'd0;
    assign o_room   = r_count <= 3'd2;
    assign pop      = o_valid && i_ready;
    assign o_result = r_mem[r_rd];
    assign wr_next  = r_wr + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + i_push.count;
            r_rd    <= r_rd + {1'b0, pop};
            r_count <= r_count + {1'b0, i_push.count} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

endmodule

### test/touch_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch event checker
// Watches the message, configuration and event channels of the touch tracker,
// predicts the events of every accepted message and compares them in order.
// ----------------------------------------------------------------------------
module touch_event_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_msg_valid,
    input  logic        i_msg_ready,
    // [7:0] status_byte, [14:8] first_data, [21:15] second_data
    input  logic [23:0] i_msg_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_evt_valid,
    input  logic        i_evt_ready,
    // [3:0] touch_id, [20:4] note_pos, [34:21] x_bend, [41:35] y_timbre,
    // [48:42] z_pressure, [56:49] control_number, [70:57] control_level
    input  logic [71:0] i_evt_data,
    // [1:0] event_kind
    input  logic [1:0]  i_evt_user,
    input  logic        i_evt_last,
    output int          o_mismatches,
    output int          o_pending
);
    import mtt_pkg::*;

    t_result expected_events[$];
    int      mismatch_count = 0;

    // Configuration and per-channel touch records as the block should hold them.
    logic               mode_mpe;
    logic [6:0]         bend_semis;
    logic               touch_live [NUM_CHANNELS];
    logic [6:0]         base_note  [NUM_CHANNELS];
    logic signed [16:0] pitch_pos  [NUM_CHANNELS];
    logic signed [13:0] bend_off   [NUM_CHANNELS];
    logic [6:0]         timbre     [NUM_CHANNELS];
    logic [6:0]         press      [NUM_CHANNELS];

    t_result seen_event;

    function automatic t_result touch_event(t_kind kind, logic [3:0] ch);
        t_result ev;
        ev            = '0;
        ev.event_kind = kind;
        ev.touch_id   = ch;
        ev.note_pos   = pitch_pos[ch];
        ev.x_bend     = bend_off[ch];
        ev.y_timbre   = timbre[ch];
        ev.z_pressure = press[ch];
        return ev;
    endfunction

    function automatic t_result control_event(logic [7:0] number, logic signed [13:0] level);
        t_result ev;
        ev                = '0;
        ev.event_kind     = KIND_CTRL;
        ev.control_number = number;
        ev.control_level  = level;
        return ev;
    endfunction

    // Applies one message to the touch records and queues the events it causes.
    task automatic track_message(logic [7:0] status, logic [6:0] d1, logic [6:0] d2);
        t_result    run [2];
        int         n;
        int         i;
        int         offset;
        int         term;
        logic [3:0] ch;
        n      = 0;
        ch     = status[3:0];
        offset = int'({d2, d1}) - 8192;
        case (status[7:4])
            MSG_NOTE_ON: begin
                // In MPE mode a note-on first closes an active touch; velocity
                // zero closes the touch even when it was idle.
                if (mode_mpe && (touch_live[ch] || d2 == 7'd0)) begin
                    timbre[ch]     = '0;
                    press[ch]      = '0;
                    touch_live[ch] = 1'b0;
                    run[n]         = touch_event(KIND_OFF, ch);
                    n++;
                    base_note[ch] = '0;
                end
                if (!mode_mpe || d2 != 7'd0) begin
                    base_note[ch]  = d1;
                    pitch_pos[ch]  = {2'b00, d1, 8'h00};
                    bend_off[ch]   = '0;
                    timbre[ch]     = '0;
                    press[ch]      = d2;
                    touch_live[ch] = 1'b1;
                    run[n]         = touch_event(KIND_ON, ch);
                    n++;
                end
            end
            MSG_NOTE_OFF: begin
                if (!mode_mpe) begin
                    pitch_pos[ch] = {2'b00, d1, 8'h00};
                    bend_off[ch]  = '0;
                end
                timbre[ch]     = '0;
                press[ch]      = d2;
                touch_live[ch] = 1'b0;
                run[n]         = touch_event(KIND_OFF, ch);
                n++;
                base_note[ch] = '0;
            end
            MSG_CTRL_CHG: begin
                if (mode_mpe && d1 == CC_TIMBRE) begin
                    if (touch_live[ch]) begin
                        timbre[ch] = d2;
                        run[n]     = touch_event(KIND_CONT, ch);
                        n++;
                    end
                end else begin
                    run[n] = control_event({1'b0, d1}, {7'd0, d2});
                    n++;
                end
            end
            MSG_CHAN_PRES: begin
                if (mode_mpe) begin
                    if (touch_live[ch]) begin
                        press[ch] = d1;
                        run[n]    = touch_event(KIND_CONT, ch);
                        n++;
                    end
                end else begin
                    run[n] = control_event(CTRL_NUM_PRESSURE, {7'd0, d1});
                    n++;
                end
            end
            MSG_PITCH_BND: begin
                if (mode_mpe) begin
                    if (touch_live[ch]) begin
                        // The arithmetic shift rounds toward minus infinity.
                        term          = (offset * int'(bend_semis)) >>> 5;
                        pitch_pos[ch] = 17'(int'(base_note[ch]) * 256 + term);
                        bend_off[ch]  = 14'(offset);
                        run[n]        = touch_event(KIND_CONT, ch);
                        n++;
                    end
                end else begin
                    run[n] = control_event(CTRL_NUM_BEND, 14'(offset));
                    n++;
                end
            end
            default: ;
        endcase
        for (i = 0; i < n; i++) begin
            if (i == n - 1) begin
                run[i].last_of_run = 1'b1;
            end
            expected_events = {expected_events, run[i]};
        end
    endtask

    task automatic check_event(t_result got);
        t_result want;
        if (expected_events.size() == 0) begin
            $error("unexpected event: event_kind %0d touch_id %0d", got.event_kind,
                   got.touch_id);
            mismatch_count++;
        end else begin
            want = expected_events.pop_front();
            if (got.event_kind != want.event_kind) begin
                $error("event_kind: expected %0d, actual %0d", want.event_kind,
                       got.event_kind);
                mismatch_count++;
            end
            if (got.touch_id != want.touch_id) begin
                $error("touch_id: expected %0d, actual %0d", want.touch_id, got.touch_id);
                mismatch_count++;
            end
            if (got.note_pos != want.note_pos) begin
                $error("note_pos: expected %0d, actual %0d", want.note_pos, got.note_pos);
                mismatch_count++;
            end
            if (got.x_bend != want.x_bend) begin
                $error("x_bend: expected %0d, actual %0d", want.x_bend, got.x_bend);
                mismatch_count++;
            end
            if (got.y_timbre != want.y_timbre) begin
                $error("y_timbre: expected %0d, actual %0d", want.y_timbre, got.y_timbre);
                mismatch_count++;
            end
            if (got.z_pressure != want.z_pressure) begin
                $error("z_pressure: expected %0d, actual %0d", want.z_pressure,
                       got.z_pressure);
                mismatch_count++;
            end
            if (got.control_number != want.control_number) begin
                $error("control_number: expected %0d, actual %0d", want.control_number,
                       got.control_number);
                mismatch_count++;
            end
            if (got.control_level != want.control_level) begin
                $error("control_level: expected %0d, actual %0d", want.control_level,
                       got.control_level);
                mismatch_count++;
            end
            if (got.last_of_run != want.last_of_run) begin
                $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                       got.last_of_run);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_mpe   = 1'b1;
            bend_semis = BEND_RANGE_RESET;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                touch_live[c] = 1'b0;
                base_note[c]  = '0;
                pitch_pos[c]  = '0;
                bend_off[c]   = '0;
                timbre[c]     = '0;
                press[c]      = '0;
            end
            expected_events.delete();
        end else begin
            if (i_evt_valid && i_evt_ready) begin
                seen_event                = '0;
                seen_event.event_kind     = t_kind'(i_evt_user);
                seen_event.touch_id       = i_evt_data[3:0];
                seen_event.note_pos       = i_evt_data[20:4];
                seen_event.x_bend         = i_evt_data[34:21];
                seen_event.y_timbre       = i_evt_data[41:35];
                seen_event.z_pressure     = i_evt_data[48:42];
                seen_event.control_number = i_evt_data[56:49];
                seen_event.control_level  = i_evt_data[70:57];
                seen_event.last_of_run    = i_evt_last;
                check_event(seen_event);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MPE_MODE:   mode_mpe   = i_cfg_data[0];
                    REG_BEND_RANGE: bend_semis = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_msg_valid && i_msg_ready) begin
                track_message(i_msg_data[7:0], i_msg_data[14:8], i_msg_data[21:15]);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_events.size();
    end

endmodule

### test/tb_mpe_midi_to_touch_tracker_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch tracker testbench
// Drives MIDI channel messages and register writes into the touch tracker,
// stalls the event stream, and leaves prediction and comparison to a checker.
// ----------------------------------------------------------------------------
module tb_mpe_midi_to_touch_tracker_unit;
    import mtt_pkg::*;

    // Message types that the tracker does not handle; they must pass silently.
    localparam logic [3:0] MSG_POLY_TOUCH = 4'hA;
    localparam logic [3:0] MSG_PROGRAM    = 4'hC;
    localparam logic [3:0] MSG_SYSTEM     = 4'hF;
    localparam logic [3:0] MSG_DATA_BYTE  = 4'h7;

    // Register indexes beyond the defined list; writes to them are dropped.
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int PHASE_COUNT      = 8;
    localparam int MSGS_PER_PHASE   = 110;
    localparam int SETTLE_CYCLES    = 6;
    localparam int HOLD_CYCLES      = 300;
    localparam int HOLD_SPACING     = 500;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TWO_OF_THREE
    } t_rx_pattern;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [6:0]  i_cfg_data;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int mismatches;
    int pending;
    int cycle_count = 0;

    // Sender state: transfers left in the current burst, and the number of
    // handled messages sent so far (ignored types do not count).
    int burst_left = 0;
    int handled_sent = 0;

    mpe_midi_to_touch_tracker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    touch_event_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_msg_valid  (s_axis_tvalid),
        .i_msg_ready  (s_axis_tready),
        .i_msg_data   (s_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_evt_valid  (m_axis_tvalid),
        .i_evt_ready  (m_axis_tready),
        .i_evt_data   (m_axis_tdata),
        .i_evt_user   (m_axis_tuser),
        .i_evt_last   (m_axis_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog. The limit is several times the slowest legal run: every message
    // with two events, the receiver at its sparsest, the sender at its widest gaps.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver. It cycles through stall patterns of its own and, every few
    // hundred events, holds off for a long stretch while the sender is busy, so
    // that the event queue inside the block fills and the message input stalls.
    initial begin
        t_rx_pattern pattern;
        int          pattern_age;
        int          hold_left;
        int          events_taken;
        int          next_hold_at;
        logic        sender_busy;
        pattern       = RX_OPEN;
        pattern_age   = 0;
        hold_left     = 0;
        events_taken  = 0;
        next_hold_at  = 200;
        sender_busy   = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                events_taken++;
            end
            sender_busy = s_axis_tvalid;
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (events_taken >= next_hold_at && sender_busy) begin
                hold_left     = HOLD_CYCLES;
                next_hold_at  = events_taken + HOLD_SPACING;
                m_axis_tready <= 1'b0;
            end else begin
                pattern_age++;
                if (pattern_age >= 50) begin
                    pattern_age = 0;
                    pattern     = t_rx_pattern'($urandom_range(0, 3));
                end
                case (pattern)
                    RX_OPEN:         m_axis_tready <= 1'b1;
                    RX_COIN:         m_axis_tready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    RX_TWO_OF_THREE: m_axis_tready <= (pattern_age % 3 != 0);
                    default:         m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    // Offers one message and returns at the falling edge after its transfer.
    // Messages go out in bursts; a new burst may start right away or after a
    // random gap. The valid line is only lowered when a real gap follows, so
    // back-to-back messages never see two assignments in one time step.
    task automatic offer(input logic [7:0] status, input logic [6:0] d1,
                         input logic [6:0] d2);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, d2, d1, status};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        case (status[7:4])
            MSG_NOTE_OFF, MSG_NOTE_ON, MSG_CTRL_CHG, MSG_CHAN_PRES, MSG_PITCH_BND:
                handled_sent++;
            default: ;
        endcase
    endtask

    // Stops sending and waits until every predicted event has been taken, then
    // waits on so that a message that causes no event has also been processed
    // before the configuration changes.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        burst_left = 0;
    endtask

    // One register write. Valid is dropped before returning, so a following
    // write raises it in a later time step.
    task automatic write_reg(input logic [1:0] index, input logic [6:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // A typical MPE gesture on one channel: note-on, a handful of timbre,
    // pressure and bend updates, then a release, a zero-velocity note-on, a
    // retrigger, or nothing (the touch stays open). Now and then the note-on
    // is left out so that updates land on an idle channel.
    task automatic play_voice(input logic [3:0] ch);
        logic [6:0] note;
        int         updates;
        note    = 7'($urandom_range(0, 127));
        updates = $urandom_range(0, 6);
        if ($urandom_range(0, 7) != 0) begin
            offer({MSG_NOTE_ON, ch}, note, 7'($urandom_range(1, 127)));
        end
        repeat (updates) begin
            case ($urandom_range(0, 3))
                0: offer({MSG_CTRL_CHG, ch}, CC_TIMBRE, 7'($urandom_range(0, 127)));
                1: offer({MSG_CHAN_PRES, ch}, 7'($urandom_range(0, 127)), 7'd0);
                default: offer({MSG_PITCH_BND, ch}, 7'($urandom_range(0, 127)),
                               7'($urandom_range(0, 127)));
            endcase
        end
        case ($urandom_range(0, 5))
            0, 1, 2: offer({MSG_NOTE_OFF, ch}, note, 7'($urandom_range(0, 127)));
            3:       offer({MSG_NOTE_ON, ch}, note, 7'd0);
            4:       ;
            default: offer({MSG_NOTE_ON, ch}, 7'($urandom_range(0, 127)),
                           7'($urandom_range(1, 127)));
        endcase
    endtask

    initial begin
        logic       phase_mpe;
        logic [6:0] phase_range;
        int         target;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_MPE_MODE;
        i_cfg_data    = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset settings: MPE mode, 48 semitone bend range.
        // Full-scale bends both ways, extremes of timbre and pressure, a
        // restart of an active touch, updates to idle channels, zero-velocity
        // note-ons with and without an open touch, a non-timbre controller, and
        // message types that are ignored.
        offer({MSG_NOTE_ON, 4'd0}, 7'd0, 7'd127);
        offer({MSG_PITCH_BND, 4'd0}, 7'd0, 7'd0);
        offer({MSG_PITCH_BND, 4'd0}, 7'd127, 7'd127);
        offer({MSG_CTRL_CHG, 4'd0}, CC_TIMBRE, 7'd127);
        offer({MSG_CHAN_PRES, 4'd0}, 7'd0, 7'd0);
        offer({MSG_CHAN_PRES, 4'd0}, 7'd127, 7'd0);
        offer({MSG_NOTE_ON, 4'd0}, 7'd127, 7'd1);
        offer({MSG_PITCH_BND, 4'd0}, 7'd127, 7'd127);
        offer({MSG_NOTE_OFF, 4'd0}, 7'd127, 7'd127);
        offer({MSG_CTRL_CHG, 4'd0}, CC_TIMBRE, 7'd5);
        offer({MSG_CHAN_PRES, 4'd5}, 7'd64, 7'd0);
        offer({MSG_PITCH_BND, 4'd15}, 7'd0, 7'd64);
        offer({MSG_NOTE_ON, 4'd15}, 7'd60, 7'd0);
        offer({MSG_NOTE_ON, 4'd15}, 7'd64, 7'd100);
        offer({MSG_NOTE_ON, 4'd15}, 7'd64, 7'd0);
        offer({MSG_CTRL_CHG, 4'd3}, 7'd7, 7'd127);
        offer({MSG_POLY_TOUCH, 4'd2}, 7'd10, 7'd20);
        offer({MSG_PROGRAM, 4'd4}, 7'd127, 7'd0);
        offer({MSG_SYSTEM, 4'hF}, 7'd127, 7'd127);
        offer({MSG_DATA_BYTE, 4'hF}, 7'd0, 7'd0);
        offer({MSG_NOTE_OFF, 4'd9}, 7'd33, 7'd0);
        settle();

        // Plain mode: notes pass through, everything else becomes a control.
        write_reg(REG_MPE_MODE, 7'd0);
        offer({MSG_NOTE_ON, 4'd1}, 7'd0, 7'd0);
        offer({MSG_NOTE_OFF, 4'd1}, 7'd127, 7'd127);
        offer({MSG_CTRL_CHG, 4'd1}, CC_TIMBRE, 7'd99);
        offer({MSG_CTRL_CHG, 4'd14}, 7'd127, 7'd127);
        offer({MSG_CHAN_PRES, 4'd1}, 7'd127, 7'd0);
        offer({MSG_PITCH_BND, 4'd1}, 7'd0, 7'd0);
        offer({MSG_PITCH_BND, 4'd1}, 7'd127, 7'd127);
        settle();

        // Random part. Each phase writes both registers (mode writes carry random
        // upper bits that must be dropped) and then plays mostly well-formed gestures
        // with some random noise; the phases between them cover the range extremes.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       begin phase_mpe = 1'b1; phase_range = BEND_RANGE_RESET; end
                1:       begin phase_mpe = 1'b0; phase_range = 7'd96;  end
                2:       begin phase_mpe = 1'b1; phase_range = 7'd0;   end
                3:       begin phase_mpe = 1'b1; phase_range = 7'd96;  end
                4:       begin phase_mpe = 1'b1; phase_range = 7'd127; end
                5:       begin phase_mpe = 1'b0; phase_range = 7'd0;   end
                6:       begin phase_mpe = 1'b1; phase_range = 7'd1;   end
                default: begin
                    phase_mpe   = 1'b1;
                    phase_range = 7'($urandom_range(0, 127));
                end
            endcase
            write_reg(REG_MPE_MODE, {6'($urandom_range(0, 63)), phase_mpe});
            write_reg(REG_BEND_RANGE, phase_range);
            if (p == 3) begin
                // Writes to spare indexes must leave both registers alone.
                write_reg(REG_SPARE_A, 7'd0);
                write_reg(REG_SPARE_B, 7'd127);
            end
            target = handled_sent + MSGS_PER_PHASE;
            while (handled_sent < target) begin
                if ($urandom_range(0, 9) < 8) begin
                    play_voice(4'($urandom_range(0, 15)));
                end else begin
                    offer(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                          7'($urandom_range(0, 127)));
                end
            end
            settle();
        end

        // All events are in and the block has had time to finish; anything
        // still predicted at this point was never delivered.
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/mtt_pkg.sv
rtl/mtt_core.sv
rtl/mtt_fifo.sv
rtl/mpe_midi_to_touch_tracker_unit.sv
test/touch_event_checker.sv
test/tb_mpe_midi_to_touch_tracker_unit.sv
